// ----- hw/rtl/fspl_pkg.sv -----
// shared constants and control types for the frame sound pressure level unit
`timescale 1ns / 1ps
package fspl_pkg;

   localparam int FRAME_MAX_DEFAULT = 1024;
   localparam int RAW_W             = 32;
   localparam int SAMPLE_LSB        = 14;
   localparam int MAG_W             = 18;
   localparam int SQUARE_W          = 35;
   localparam int LEVEL_W           = 17;
   localparam int CAL_W             = 15;
   localparam int FRAC_W            = 16;
   localparam int MANT_W            = 31;
   localparam int COEF_W            = 27;

   localparam logic [CAL_W-1:0]          CAL_RESET     = 15'd24064;
   localparam logic signed [LEVEL_W-1:0] FIXED_TERM    = -17'sd2143;
   localparam logic signed [LEVEL_W-1:0] FLOOR_LEVEL   = -17'sd27141;
   localparam logic signed [COEF_W-1:0]  DB_PER_OCTAVE = 27'sd50504453;

   // commands from the controller to the datapath
   typedef struct packed {
      logic take;
      logic accum;
      logic check;
      logic shift;
      logic load_mant;
      logic frac_step;
      logic save_a;
      logic load_b;
      logic scale;
      logic finish;
   } fspl_cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic msb_set;
      logic sum_zero;
      logic frame_end;
      logic out_free;
   } fspl_status_type;

endpackage

// ----- hw/rtl/fspl_req_if.sv -----
// request and response channel interfaces
`timescale 1ns / 1ps
interface fspl_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] raw_word;
   logic               frame_end;
   modport source (output valid, output raw_word, output frame_end, input ready);
   modport sink   (input valid, input raw_word, input frame_end, output ready);
endinterface

interface fspl_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [16:0] level_db;
   logic               floor_hit;
   modport source (output valid, output level_db, output floor_hit, input ready);
   modport sink   (input valid, input level_db, input floor_hit, output ready);
endinterface

// ----- hw/rtl/frame_sound_pressure_level_unit.sv -----
// frame sound pressure level unit, top level
//
//   channel       dir  handshake     payload
//   req_channel   in   valid/ready   raw_word[31:0] signed, frame_end
//   rsp_channel   out  valid/ready   level_db[16:0] signed, floor_hit
//   csr_*         in   csr_wr_en     csr_wr_data[14:0] calibration offset
//
// an ordinary request is squared when taken, then accumulated
// a frame end request adds a frame check and two passes of the shared log2
// unit (msb search one bit a cycle, then 16 squaring steps), one scale
// multiply and the final add; a silent frame goes from the check to the add
// the response register lets the next frame start while a level waits; a
// second finished level stalls the input until the first is taken
// synchronous active-high reset clears accumulators and loads offset 94 dB
`timescale 1ns / 1ps
module frame_sound_pressure_level_unit #(
   parameter int FRAME_MAX = fspl_pkg::FRAME_MAX_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   fspl_req_if.sink                   req_channel,
   fspl_rsp_if.source                 rsp_channel,
   input  logic                       csr_wr_en,
   input  logic [fspl_pkg::CAL_W-1:0] csr_wr_data
);
   import fspl_pkg::*;

   fspl_cmd_type    cmd;
   fspl_status_type status;
   logic            req_ready;

   // sequencer: intake, frame check, log passes, scaling
   fspl_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_channel.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // accumulators, log2 unit, level math and response register
   fspl_datapath #(
      .FRAME_MAX (FRAME_MAX)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .raw_word    (req_channel.raw_word),
      .frame_end   (req_channel.frame_end),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_channel (rsp_channel)
   );

   assign req_channel.ready = req_ready;

`ifndef SYNTHESIS
   // an accepted request is accumulated in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      (req_channel.valid && req_ready) |=> cmd.accum)
      else $error("accepted request not accumulated");

   // a level is only loaded when the response register is free
   assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> status.out_free)
      else $error("response overwritten");

   // a finished frame is presented at the output
   assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> rsp_channel.valid)
      else $error("finished frame not presented");
`endif
endmodule

// ----- hw/rtl/fspl_datapath.sv -----
// accumulators, shared log2 unit, scaling and response register
`timescale 1ns / 1ps
module fspl_datapath #(
   parameter int FRAME_MAX = 1024
) (
   input  logic                          clock,
   input  logic                          reset,
   input  fspl_pkg::fspl_cmd_type        cmd,
   output fspl_pkg::fspl_status_type     status,
   input  logic signed [31:0]            raw_word,
   input  logic                          frame_end,
   input  logic                          csr_wr_en,
   input  logic [fspl_pkg::CAL_W-1:0]    csr_wr_data,
   fspl_rsp_if.source                    rsp_channel
);
   import fspl_pkg::*;

   localparam int CNT_W  = $clog2(FRAME_MAX + 1);
   localparam int SUM_W  = SQUARE_W + CNT_W;
   localparam int E_W    = $clog2(SUM_W);
   localparam int LOG_W  = E_W + FRAC_W;
   localparam int D_W    = LOG_W + 1;
   localparam int P_W    = D_W + COEF_W;
   localparam int WIDE_W = P_W - 32 + 2;
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(FRAME_MAX);

   logic [CAL_W-1:0]    cal_ff, cal_in;
   logic [SQUARE_W-1:0] sq_ff, sq_in;
   logic                fe_ff, fe_in;
   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [SUM_W-1:0]    x_ff, x_in;
   logic [E_W-1:0]      e_ff, e_in;
   logic [MANT_W-1:0]   m_ff, m_in;
   logic [FRAC_W-1:0]   frac_ff, frac_in;
   logic [LOG_W-1:0]    log_a_ff, log_a_in;
   logic                floor_ff, floor_in;
   logic signed [P_W-1:0] p_ff, p_in;
   logic                valid_ff, valid_in;
   logic signed [LEVEL_W-1:0] level_ff, level_in;
   logic                hit_ff, hit_in;

   logic [17:0]         field;
   logic [MAG_W-1:0]    mag;
   logic [2*MAG_W-1:0]  mag_sq;
   logic signed [P_W-1:0] prod;
   logic [2*MANT_W-1:0] msq;
   logic [MANT_W:0]     t;
   logic signed [D_W-1:0] d;
   logic signed [P_W-1:0] p_round;
   logic signed [WIDE_W-1:0] level_wide;

   always_comb begin
      field  = raw_word[RAW_W-1:SAMPLE_LSB];
      mag    = field[17] ? MAG_W'(18'h0 - field) : field;
      mag_sq = mag * mag;
      msq    = m_ff * m_ff;
      t      = msq[2*MANT_W-1:MANT_W-1];
      d      = $signed({1'b0, log_a_ff}) - $signed({1'b0, e_ff, frac_ff});
      prod   = d * DB_PER_OCTAVE;
      p_round = p_ff + (P_W'(1) <<< 31);
      level_wide = WIDE_W'(p_round >>> 32) + WIDE_W'(FIXED_TERM)
                 + $signed({{(WIDE_W-CAL_W){1'b0}}, cal_ff});
   end

   always_comb begin
      cal_in   = csr_wr_en ? csr_wr_data : cal_ff;
      sq_in    = cmd.take ? mag_sq[SQUARE_W-1:0] : sq_ff;
      fe_in    = cmd.take ? frame_end : fe_ff;
      sum_in   = sum_ff;
      count_in = count_ff;
      if (cmd.accum && count_ff < CNT_MAX) begin
         sum_in   = sum_ff + SUM_W'(sq_ff);
         count_in = count_ff + CNT_W'(1);
      end
      if (cmd.finish) begin
         sum_in   = '0;
         count_in = '0;
      end
      x_in     = x_ff;
      e_in     = e_ff;
      m_in     = m_ff;
      frac_in  = frac_ff;
      log_a_in = log_a_ff;
      floor_in = floor_ff;
      p_in     = p_ff;
      if (cmd.check) begin
         x_in     = sum_ff;
         e_in     = E_W'(SUM_W - 1);
         floor_in = (sum_ff == '0) || (count_ff == '0);
      end
      if (cmd.save_a) begin
         log_a_in = {e_ff, frac_ff};
      end
      if (cmd.load_b) begin
         x_in = {{(SUM_W-CNT_W){1'b0}}, count_ff};
         e_in = E_W'(SUM_W - 1);
      end
      if (cmd.shift) begin
         x_in = {x_ff[SUM_W-2:0], 1'b0};
         e_in = e_ff - E_W'(1);
      end
      if (cmd.load_mant) begin
         m_in    = x_ff[SUM_W-1 -: MANT_W];
         frac_in = '0;
      end
      if (cmd.frac_step) begin
         m_in    = t[MANT_W] ? t[MANT_W:1] : t[MANT_W-1:0];
         frac_in = {frac_ff[FRAC_W-2:0], t[MANT_W]};
      end
      if (cmd.scale) begin
         p_in = prod;
      end
      valid_in = valid_ff && !rsp_channel.ready;
      level_in = level_ff;
      hit_in   = hit_ff;
      if (cmd.finish) begin
         valid_in = 1'b1;
         hit_in   = floor_ff;
         level_in = floor_ff ? FLOOR_LEVEL + $signed({2'b00, cal_ff})
                             : level_wide[LEVEL_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cal_ff   <= CAL_RESET;
         sum_ff   <= '0;
         count_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         cal_ff   <= cal_in;
         sum_ff   <= sum_in;
         count_ff <= count_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sq_ff    <= sq_in;
      fe_ff    <= fe_in;
      x_ff     <= x_in;
      e_ff     <= e_in;
      m_ff     <= m_in;
      frac_ff  <= frac_in;
      log_a_ff <= log_a_in;
      floor_ff <= floor_in;
      p_ff     <= p_in;
      level_ff <= level_in;
      hit_ff   <= hit_in;
   end

   assign status.msb_set   = x_ff[SUM_W-1];
   assign status.sum_zero  = (sum_ff == '0) || (count_ff == '0);
   assign status.frame_end = fe_ff;
   assign status.out_free  = !valid_ff || rsp_channel.ready;

   assign rsp_channel.valid     = valid_ff;
   assign rsp_channel.level_db  = level_ff;
   assign rsp_channel.floor_hit = hit_ff;
endmodule

// ----- hw/rtl/fspl_controller.sv -----
// sequencing state machine for sample intake and frame level computation
`timescale 1ns / 1ps
module fspl_controller (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  fspl_pkg::fspl_status_type   status,
   output fspl_pkg::fspl_cmd_type      cmd
);
   import fspl_pkg::*;

   typedef enum logic [7:0] {
      ST_IDLE = 8'b0000_0001,
      ST_ACC  = 8'b0000_0010,
      ST_CHK  = 8'b0000_0100,
      ST_NORM = 8'b0000_1000,
      ST_FRAC = 8'b0001_0000,
      ST_NEXT = 8'b0010_0000,
      ST_MUL  = 8'b0100_0000,
      ST_FIN  = 8'b1000_0000
   } state_type;

   state_type  state_ff, state_in;
   logic [3:0] bit_ff, bit_in;
   logic       pass_ff, pass_in;

   always_comb begin
      state_in  = state_ff;
      bit_in    = bit_ff;
      pass_in   = pass_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.take = 1'b1;
               state_in = ST_ACC;
            end
         end
         ST_ACC: begin
            cmd.accum = 1'b1;
            state_in  = status.frame_end ? ST_CHK : ST_IDLE;
         end
         ST_CHK: begin
            cmd.check = 1'b1;
            pass_in   = 1'b0;
            state_in  = status.sum_zero ? ST_FIN : ST_NORM;
         end
         ST_NORM: begin
            if (status.msb_set) begin
               cmd.load_mant = 1'b1;
               bit_in        = 4'hf;
               state_in      = ST_FRAC;
            end else begin
               cmd.shift = 1'b1;
            end
         end
         ST_FRAC: begin
            cmd.frac_step = 1'b1;
            bit_in        = bit_ff - 4'd1;
            if (bit_ff == 4'd0) state_in = ST_NEXT;
         end
         ST_NEXT: begin
            if (!pass_ff) begin
               cmd.save_a = 1'b1;
               cmd.load_b = 1'b1;
               pass_in    = 1'b1;
               state_in   = ST_NORM;
            end else begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.scale = 1'b1;
            state_in  = ST_FIN;
         end
         ST_FIN: begin
            if (status.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pass_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         pass_ff  <= pass_in;
      end
   end

   always_ff @(posedge clock) begin
      bit_ff <= bit_in;
   end
endmodule
